### hw/rtl/pcksum_pkg.sv
// ----------------------------------------------------------------------------
// pcksum_pkg: shared types, constants and CRC helpers
// Holds the queue entry layout, the register map and the byte-wise CRC-32
// step that builds a table entry from the configured polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

package pcksum_pkg;

   // Register map and reset values.
   localparam logic [31:0] POLY_RESET     = 32'h04C1_1DB7;
   localparam int          CSR_ADDR_WIDTH = 3;
   localparam logic        CSR_IDX_POLY   = 1'b0;

   // Depth of the queue between the front and the back part.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Mask used by the front part's byte counter.
   localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFF;

   // One classified request as it travels from the front to the back part.
   typedef struct packed {
      logic [31:0] count;     // byte count of the stream, valid on the last byte
      logic        ovf;       // the stream's byte count has passed 2^32 - 1
      logic        skip;      // this byte does not enter the CRC
      logic        last;      // final byte of the stream
      logic [7:0]  data;      // the byte itself
   } qentry_type;

   // One table entry for the given index, built bit by bit from the polynomial.
   function automatic logic [31:0] table_entry(input logic [7:0] idx,
                                               input logic [31:0] poly);
      logic [31:0] t;
      t = {idx, 24'h0};
      for (int b = 0; b < 8; b++) begin
         if (t[31]) begin
            t = {t[30:0], 1'b0} ^ poly;
         end else begin
            t = {t[30:0], 1'b0};
         end
      end
      return t;
   endfunction

   // One MSB-first CRC step over a single byte.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                            input logic [7:0]  data,
                                            input logic [31:0] poly);
      logic [7:0] idx;
      idx = crc[31:24] ^ data;
      return {crc[23:0], 8'h00} ^ table_entry(idx, poly);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/pcksum_front.sv
// ----------------------------------------------------------------------------
// pcksum_front: request intake and classification
// Counts the bytes of each stream, tracks count wrap and tags every byte
// with what the back part has to do with it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcksum_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire  [7:0]              req_tdata,
   input  wire                     req_tlast,
   input  wire                     q_full,
   output logic                    q_push,
   output pcksum_pkg::qentry_type  q_entry
);

   logic [31:0] count_ff, count_in;
   logic        ovf_ff, ovf_in;
   logic        accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept;

   // Classify the byte and advance the stream counters.
   always_comb begin
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      q_entry.data  = req_tdata;
      q_entry.last  = req_tlast;
      q_entry.skip  = 1'b1;
      if (!ovf_ff) begin
         if (count_ff == pcksum_pkg::WORD_MASK) begin
            ovf_in = 1'b1;
         end else begin
            count_in     = count_ff + 32'd1;
            q_entry.skip = 1'b0;
         end
      end
      q_entry.count = count_in;
      q_entry.ovf   = ovf_in;
      // The stream ends here, so the next request starts a fresh one.
      if (req_tlast) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/pcksum_fifo.sv
// ----------------------------------------------------------------------------
// pcksum_fifo: short queue between the front and the back part
// A small register-based first-in first-out buffer of classified requests.
// ----------------------------------------------------------------------------
`default_nettype none

module pcksum_fifo #(
   parameter int DEPTH = pcksum_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wire pcksum_pkg::qentry_type push_entry,
   output logic                    full,
   input  wire                     pop,
   output logic                    not_empty,
   output pcksum_pkg::qentry_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   pcksum_pkg::qentry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == FULL_CNT);
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/pcksum_back.sv
// ----------------------------------------------------------------------------
// pcksum_back: CRC engine and result register
// Folds bytes into the CRC, appends the length trailer at the end of a
// stream and presents the checksum in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcksum_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire  [31:0]             poly,
   input  wire                     q_valid,
   input  wire pcksum_pkg::qentry_type q_head,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [63:0]             rsp_tdata,
   output logic                    rsp_tuser
);

   localparam logic [1:0] ST_BYTE  = 2'd0;
   localparam logic [1:0] ST_TRAIL = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] cnt_ff, cnt_in;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_data_ff, out_data_in;
   logic        out_ovf_ff, out_ovf_in;
   logic        out_free, load_out;
   logic [7:0]  crc_src;
   logic [31:0] crc_next;

   assign out_free = !out_valid_ff || rsp_tready;

   // One shared byte step: request bytes in ST_BYTE, length bytes otherwise.
   assign crc_src  = (state_ff == ST_BYTE) ? q_head.data : len_ff[7:0];
   assign crc_next = pcksum_pkg::crc_byte(crc_ff, crc_src, poly);

   // Sequencer for the byte stream and the length trailer.
   always_comb begin
      state_in    = state_ff;
      crc_in      = crc_ff;
      len_in      = len_ff;
      cnt_in      = cnt_ff;
      q_pop       = 1'b0;
      load_out    = 1'b0;
      out_data_in = out_data_ff;
      out_ovf_in  = out_ovf_ff;
      case (state_ff)
         ST_BYTE: begin
            if (q_valid) begin
               if (q_head.last && q_head.ovf) begin
                  // Wrapped stream: report the error and start over.
                  if (out_free) begin
                     q_pop       = 1'b1;
                     load_out    = 1'b1;
                     out_data_in = '0;
                     out_ovf_in  = 1'b1;
                     crc_in      = '0;
                  end
               end else begin
                  q_pop = 1'b1;
                  if (!q_head.skip) begin
                     crc_in = crc_next;
                  end
                  if (q_head.last) begin
                     len_in   = q_head.count;
                     cnt_in   = q_head.count;
                     state_in = ST_TRAIL;
                  end
               end
            end
         end
         ST_TRAIL: begin
            crc_in = crc_next;
            len_in = {8'h00, len_ff[31:8]};
            if (len_ff[31:8] == 24'h0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               load_out    = 1'b1;
               out_data_in = {cnt_ff, ~crc_ff};
               out_ovf_in  = 1'b0;
               crc_in      = '0;
               state_in    = ST_BYTE;
            end
         end
         default: begin
            state_in = ST_BYTE;
         end
      endcase
   end

   // Output register handshake.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BYTE;
         crc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      cnt_ff      <= cnt_in;
      out_data_ff <= out_data_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_ovf_ff;

endmodule

`default_nettype wire

### hw/rtl/posix_cksum_crc32_stream.sv
// ----------------------------------------------------------------------------
// posix_cksum_crc32_stream: streaming POSIX cksum CRC-32
// Byte stream in, one checksum and length result out per stream.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle into a short queue while it is not full
// and folds one byte per cycle into the CRC in its back part; the single
// byte-wide CRC step there sets the sustained rate of one byte per cycle
// away from stream ends, where the back part folds in one length byte per
// significant byte of the count and loads the result register once the
// output is free, while the front part keeps filling the queue. A stream
// whose byte count passes 2^32 - 1 yields a result with the overflow flag
// set and zero data. The polynomial register takes effect on the next byte.
`default_nettype none

module posix_cksum_crc32_stream #(
   parameter int QUEUE_DEPTH = pcksum_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // Request stream.
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [7:0]                           req_tdata,  // [7:0] data_byte
   input  wire                                  req_tlast,  // is_last
   // Result stream.
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [63:0]                          rsp_tdata,  // [31:0] crc_value,
                                                            // [63:32] byte_count
   output logic                                 rsp_tuser,  // count_overflow
   // Configuration port.
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [pcksum_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire  [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   logic [31:0]            poly_ff;
   logic                   q_full, q_push, q_pop, q_valid;
   pcksum_pkg::qentry_type q_entry, q_head;
   logic                   csr_wr;

   // Polynomial register.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= pcksum_pkg::POLY_RESET;
      end else if (csr_wr && (csr_paddr[2] == pcksum_pkg::CSR_IDX_POLY)) begin
         poly_ff <= csr_pwdata;
      end
   end

   assign csr_prdata = (csr_paddr[2] == pcksum_pkg::CSR_IDX_POLY) ? poly_ff : '0;

   pcksum_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   pcksum_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_valid),
      .head       (q_head)
   );

   pcksum_back u_back (
      .clock      (clock),
      .reset      (reset),
      .poly       (poly_ff),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### hw/rtl/pcksum_checker.sv
// ----------------------------------------------------------------------------
// pcksum_checker: port-level checks for the cksum stream block
// Watches the top-level ports and flags results that cannot be right.
// ----------------------------------------------------------------------------
`default_nettype none

module pcksum_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [63:0] rsp_tdata,
   input wire        rsp_tuser,
   input wire        csr_pready
);

   // A stalled result holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // An overflow result carries no checksum and no length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 64'h0)
      else $error("overflow result with nonzero data");

   // A good result always counts at least the last byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[63:32] != 32'h0)
      else $error("result with zero byte count");

   // The configuration port never waits.
   assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("configuration port not ready");

endmodule

bind posix_cksum_crc32_stream pcksum_checker u_pcksum_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);

`default_nettype wire
